FILE: sv/bbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_pkg
// Types and constants shared by the box rescaler modules.
// ----------------------------------------------------------------------------
package bbr_pkg;

	localparam int CoordBits      = 32;
	localparam int ScaleFracBits  = 30;
	localparam int ScaleBits      = ScaleFracBits + 2;
	localparam int RootFloorShift = 8;
	localparam int GainFracBits   = 24;
	localparam int PressFracBits  = 16;
	localparam int GainShift      = GainFracBits + PressFracBits - ScaleFracBits;
	localparam int RootSteps      = ScaleFracBits + 2;
	localparam int StepBits       = $clog2(RootSteps + 1);
	localparam int QueueDepth     = 2;
	localparam int QueueIdxBits   = 1;

	// 2^33 / 3 rounded up, exact division by three for magnitudes below 2^33
	localparam logic [31:0] Recip3      = 32'hAAAA_AAAB;
	localparam int          Recip3Shift = 33;

	localparam logic [ScaleBits-1:0] ScaleOne = ScaleBits'(1) << ScaleFracBits;

	localparam logic [1:0] MODE_ISO   = 2'd0;
	localparam logic [1:0] MODE_ANISO = 2'd1;
	localparam logic [1:0] MODE_SEMI  = 2'd2;
	localparam logic [1:0] MODE_ONED  = 2'd3;

	localparam logic OP_STEP = 1'b0;
	localparam logic OP_POS  = 1'b1;

	localparam logic [0:0] REG_MODE = 1'b0;
	localparam logic [0:0] REG_GAIN = 1'b1;

	typedef struct packed {
		logic                        op;
		logic signed [CoordBits-1:0] coord_x;
		logic signed [CoordBits-1:0] coord_y;
		logic signed [CoordBits-1:0] coord_z;
		logic signed [31:0]          press_xx;
		logic signed [31:0]          press_yy;
		logic signed [31:0]          press_zz;
		logic                        press_ok;
		logic signed [31:0]          target_pressure;
	} in_item_t;

	typedef struct packed {
		logic                        kind;
		logic signed [CoordBits-1:0] out_x;
		logic signed [CoordBits-1:0] out_y;
		logic signed [CoordBits-1:0] out_z;
		logic                        clamped;
	} out_item_t;

	// classified item handed from the front end to the back end
	typedef struct packed {
		logic                        op;
		logic [1:0]                  mode;
		logic signed [CoordBits-1:0] cx;
		logic signed [CoordBits-1:0] cy;
		logic signed [CoordBits-1:0] cz;
		logic signed [33:0]          dx;
		logic signed [33:0]          dy;
		logic signed [33:0]          dz;
	} work_t;

endpackage
`default_nettype wire

FILE: sv/bbr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_front
// Accepts items, forms per-axis pressure differences and queues the work.
// ----------------------------------------------------------------------------
module bbr_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	output logic                 full,
	input  bbr_pkg::in_item_t    din,
	input  wire [1:0]            mode,
	output logic                 wvalid,
	input  wire                  wtake,
	output bbr_pkg::work_t       wdata
);
	import bbr_pkg::*;

	work_t                   mem_q [QueueDepth];
	logic [QueueIdxBits-1:0] wr_q, rd_q;
	logic [QueueIdxBits:0]   cnt_q;
	work_t                   w;
	logic signed [31:0]      px, py, pz, pm3, pm2;
	logic signed [33:0]      s3, s2;
	logic [32:0]             s3mag;
	logic [65:0]             q3;

	always_comb begin
		if (din.press_ok) begin
			px = din.press_xx;
			py = din.press_yy;
			pz = din.press_zz;
		end else begin
			px = din.target_pressure;
			py = din.target_pressure;
			pz = din.target_pressure;
		end
		s3  = 34'(px) + 34'(py) + 34'(pz);
		s2  = 34'(py) + 34'(pz);
		// mean of three truncated toward zero, by reciprocal on the magnitude
		s3mag = s3[33] ? 33'(-s3) : 33'(s3);
		q3    = 66'(s3mag) * 66'(Recip3);
		pm3   = s3[33] ? -32'(q3 >> Recip3Shift) : 32'(q3 >> Recip3Shift);
		pm2 = 32'(s2 / 34'sd2);
		w.op   = din.op;
		w.mode = mode;
		w.cx   = din.coord_x;
		w.cy   = din.coord_y;
		w.cz   = din.coord_z;
		w.dx   = 34'(din.target_pressure) - 34'(px);
		w.dy   = 34'(din.target_pressure) - 34'(py);
		w.dz   = 34'(din.target_pressure) - 34'(pz);
		unique case (mode)
			MODE_ISO, MODE_ONED: begin
				w.dx = 34'(din.target_pressure) - 34'(pm3);
				w.dy = w.dx;
				w.dz = w.dx;
			end
			MODE_SEMI: begin
				w.dy = 34'(din.target_pressure) - 34'(pm2);
				w.dz = w.dy;
			end
			default: ;
		endcase
	end

	assign full   = (cnt_q == (QueueIdxBits+1)'(QueueDepth));
	assign wvalid = (cnt_q != '0);
	assign wdata  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (wtake && wvalid) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QueueIdxBits+1)'(push && !full)
				- (QueueIdxBits+1)'(wtake && wvalid);
		end
	end

endmodule
`default_nettype wire

FILE: sv/bbr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_back
// Forms coupling arguments, runs the bitwise cube root and scales coordinates.
// ----------------------------------------------------------------------------
module bbr_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  wvalid,
	output logic                 wtake,
	input  bbr_pkg::work_t       wdata,
	input  wire [31:0]           gain,
	output logic                 empty,
	input  wire                  pop,
	output bbr_pkg::out_item_t   dout
);
	import bbr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ARG  = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]           st_q;
	logic [1:0]           axis_q;
	logic [StepBits-1:0]  bit_q;
	logic [1:0]           sub_q;
	work_t                cur_q;
	logic [ScaleBits-1:0] sx_q, sy_q, sz_q;
	logic [ScaleBits-1:0] arg_q, root_q, t_q;
	logic [2*ScaleBits-1:0]   sq_q;
	logic [3*ScaleBits-1:0]   cube_q;
	logic                 clamp_q;
	out_item_t            res_q;
	logic                 full_q;

	logic signed [33:0]   d;
	logic [33:0]          dmag;
	logic [65:0]          gprod;
	logic [65:0]          m;
	logic signed [ScaleBits+2:0] a;
	logic [ScaleBits-1:0] argv;
	logic                 aclamp;
	logic [3*ScaleBits-1:0] tgt;
	logic [ScaleBits-1:0] tcand;

	function automatic logic signed [CoordBits-1:0] scale_coord(
		input logic signed [CoordBits-1:0] c, input logic [ScaleBits-1:0] s);
		logic                         neg;
		logic [CoordBits-1:0]         mag;
		logic [CoordBits+ScaleBits-1:0] p;
		logic [CoordBits+ScaleBits-1:0] v;
		logic [CoordBits-1:0]         lim;
		begin
			neg = c[CoordBits-1];
			mag = neg ? CoordBits'(-c) : CoordBits'(c);
			p   = (CoordBits+ScaleBits)'(mag) * (CoordBits+ScaleBits)'(s);
			v   = p >> ScaleFracBits;
			lim = neg ? CoordBits'(1) << (CoordBits-1) : ~(CoordBits'(1) << (CoordBits-1));
			if (v > (CoordBits+ScaleBits)'(lim)) v = (CoordBits+ScaleBits)'(lim);
			scale_coord = neg ? -CoordBits'(v) : CoordBits'(v);
		end
	endfunction

	always_comb begin
		unique case (axis_q)
			2'd0:    d = cur_q.dx;
			2'd1:    d = cur_q.dy;
			default: d = cur_q.dz;
		endcase
		dmag  = d[33] ? 34'(-d) : 34'(d);
		gprod = 66'(gain) * 66'(dmag);
		m     = gprod >> GainShift;
		if (m > 66'(4) * 66'(ScaleOne)) m = 66'(4) * 66'(ScaleOne);
		a = d > 0 ? (ScaleBits+3)'(ScaleOne) - (ScaleBits+3)'(m)
			: (ScaleBits+3)'(ScaleOne) + (ScaleBits+3)'(m);
		aclamp = 1'b0;
		argv   = ScaleBits'(a);
		if (a < $signed((ScaleBits+3)'(ScaleOne >> RootFloorShift))) begin
			argv   = ScaleOne >> RootFloorShift;
			aclamp = 1'b1;
		end else if (a > $signed((ScaleBits+3)'(2 * ScaleOne - 1))) begin
			argv   = ScaleBits'(2 * ScaleOne - 1);
			aclamp = 1'b1;
		end
		tgt   = (3*ScaleBits)'(arg_q) << (2*ScaleFracBits);
		tcand = root_q | (ScaleBits'(1) << bit_q);
	end

	assign wtake = (st_q == ST_IDLE) && wvalid;
	assign empty = !full_q;
	assign dout  = res_q;

	always_ff @(posedge clk) begin
		if (wtake) cur_q <= wdata;
		if (st_q == ST_ARG) arg_q <= argv;
		if (st_q == ST_ROOT) begin
			unique case (sub_q)
				2'd0: begin
					t_q  <= tcand;
					sq_q <= (2*ScaleBits)'(tcand) * (2*ScaleBits)'(tcand);
				end
				// cube in two partial products of the square
				2'd1: cube_q <= (3*ScaleBits)'((2*ScaleBits)'(sq_q[ScaleBits-1:0])
					* (2*ScaleBits)'(t_q));
				2'd2: cube_q <= cube_q + ((3*ScaleBits)'(
					(2*ScaleBits)'(sq_q[2*ScaleBits-1:ScaleBits]) * (2*ScaleBits)'(t_q))
					<< ScaleBits);
				default: if (cube_q <= tgt) root_q <= t_q;
			endcase
		end else if (st_q == ST_ARG) begin
			root_q <= '0;
		end
		if (st_q == ST_OUT && (!full_q || pop)) begin
			res_q.kind    <= cur_q.op;
			res_q.out_x   <= scale_coord(cur_q.cx, sx_q);
			res_q.out_y   <= scale_coord(cur_q.cy, sy_q);
			res_q.out_z   <= scale_coord(cur_q.cz, sz_q);
			res_q.clamped <= clamp_q && (cur_q.op == OP_STEP);
		end
	end

	// axis order: x, then y, then z; shared factors are copied at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			axis_q  <= '0;
			bit_q   <= '0;
			sub_q   <= '0;
			clamp_q <= 1'b0;
			full_q  <= 1'b0;
			sx_q    <= ScaleOne;
			sy_q    <= ScaleOne;
			sz_q    <= ScaleOne;
		end else begin
			if (pop && full_q && st_q != ST_OUT) full_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (wvalid) begin
					axis_q  <= '0;
					clamp_q <= 1'b0;
					st_q    <= (wdata.op == OP_STEP) ? ST_ARG : ST_OUT;
				end
				ST_ARG: begin
					clamp_q <= clamp_q | aclamp;
					bit_q   <= StepBits'(RootSteps - 1);
					sub_q   <= '0;
					if (cur_q.mode == MODE_ONED) begin
						sx_q <= argv;
						sy_q <= ScaleOne;
						sz_q <= ScaleOne;
						st_q <= ST_OUT;
					end else begin
						st_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (sub_q != 2'd3) begin
						sub_q <= sub_q + 2'd1;
					end else begin
						sub_q <= '0;
						if (bit_q != '0) begin
							bit_q <= bit_q - 1'b1;
						end else begin
							st_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					unique case (axis_q)
						2'd0: sx_q <= root_q;
						2'd1: sy_q <= root_q;
						default: sz_q <= root_q;
					endcase
					if (cur_q.mode == MODE_ISO) begin
						sy_q <= root_q;
						sz_q <= root_q;
						st_q <= ST_OUT;
					end else if (cur_q.mode == MODE_SEMI && axis_q == 2'd1) begin
						sz_q <= root_q;
						st_q <= ST_OUT;
					end else if (axis_q == 2'd2) begin
						st_q <= ST_OUT;
					end else begin
						axis_q <= axis_q + 2'd1;
						st_q   <= ST_ARG;
					end
				end
				ST_OUT: if (!full_q || pop) begin
					full_q <= 1'b1;
					st_q   <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/berendsen_box_rescaler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// berendsen_box_rescaler_top
// Berendsen pressure coupling: per-axis box scale factors and position scaling.
// ----------------------------------------------------------------------------
// Input channel: push/full with one in_item_t per request. Result channel:
// empty/pop with one out_item_t per request, oldest first.
// Registers over APB: mode at 0x0, gain at 0x4; write only while idle.
// A position request goes from the queue through the output state into the
// result register, and the back end takes no new request before that. A step request runs
// the coupling argument and a bit-serial cube root per needed axis (one in isotropic,
// two in semi-isotropic, three in anisotropic mode) over 32 bits, each bit a square,
// two partial cube products and a compare; one-dimensional mode uses the argument
// as the x factor with no root. One request is worked at a time.
// A two-entry queue decouples the input side from the back end; the input
// keeps taking requests while a result waits. When pop is held low the
// result register holds, the back end stops, and full rises once the queue
// fills. Reset empties everything, sets mode and gain to zero and the scale
// factors to unity.
// ----------------------------------------------------------------------------
module berendsen_box_rescaler_top (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	output logic                 full,
	input  bbr_pkg::in_item_t    din,
	output logic                 empty,
	input  wire                  pop,
	output bbr_pkg::out_item_t   dout,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire [2:0]            paddr,
	input  wire [31:0]           pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import bbr_pkg::*;

	logic [1:0]  mode_q;
	logic [31:0] gain_q;
	logic        wvalid, wtake;
	work_t       wdata;

	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = {30'd0, mode_q};
			default:  prdata = gain_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ISO;
			gain_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0) begin
			unique case (paddr[2])
				REG_MODE: mode_q <= pwdata[1:0];
				default:  gain_q <= pwdata;
			endcase
		end
	end

	bbr_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .din(din),
		.mode(mode_q), .wvalid(wvalid), .wtake(wtake), .wdata(wdata)
	);

	bbr_back u_back (
		.clk(clk), .arst_n(arst_n), .wvalid(wvalid), .wtake(wtake), .wdata(wdata),
		.gain(gain_q), .empty(empty), .pop(pop), .dout(dout)
	);

endmodule
`default_nettype wire

FILE: sv/bbr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_checker
// Port-level checks for the box rescaler.
// ----------------------------------------------------------------------------
module bbr_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                push,
	input wire                full,
	input wire                empty,
	input wire                pop,
	input bbr_pkg::out_item_t dout,
	input wire                pready
);
	import bbr_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(dout))
		else $error("result changed while stalled");

	a_pos_noclamp: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && dout.kind == OP_POS |-> !dout.clamped)
		else $error("position result flagged clamped");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("not empty after reset");

endmodule

bind berendsen_box_rescaler_top bbr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .empty(empty),
	.pop(pop), .dout(dout), .pready(pready)
);
`default_nettype wire
